// ===== hdl/rtfc_pkg.sv =====
// Shared types and constants for the resistive touch filter and calibration block.
`default_nettype none

package rtfc_pkg;

  // Raw conversion width of the touch controller.
  localparam int SAMPLE_BITS = 12;
  localparam int SCREEN_BITS = 16;
  localparam int THRESH_BITS = 12;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 5;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(10);

  typedef enum logic [2:0] {
    REG_COEF_XX   = 3'd0,
    REG_COEF_XY   = 3'd1,
    REG_OFFSET_X  = 3'd2,
    REG_COEF_YX   = 3'd3,
    REG_COEF_YY   = 3'd4,
    REG_OFFSET_Y  = 3'd5,
    REG_MOVE_THR  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raw_x;
    logic [SAMPLE_BITS-1:0] raw_y;
    logic                   pen_up;
  } in_beat_t;

  typedef struct packed {
    logic                          event_kind;
    logic [SAMPLE_BITS-1:0]        filtered_x;
    logic [SAMPLE_BITS-1:0]        filtered_y;
    logic signed [SCREEN_BITS-1:0] screen_x;
    logic signed [SCREEN_BITS-1:0] screen_y;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== hdl/resistive_touch_filter_calibrate.sv =====
// Top level: touch sample burst filter, move detection and affine calibration pipeline.
// Accepts one sample beat per cycle. Every ninth pen-down sample closes a burst. Its result
// passes through the burst snapshot, group divide, pair pick, coefficient multiply and
// affine sum stages, each of which adds a register, and then the output register, which also
// rounds and saturates. A pen-up beat drops the partial burst and yields nothing. Throughput
// is one beat per cycle, held back only when a finished result is stalled and the pipeline
// behind it has filled up.
// Coefficients and the move threshold sit on the APB port (4-byte spaced); the user must
// write them only while the block is idle, which the block itself does not enforce.
`default_nettype none

module resistive_touch_filter_calibrate #(
  parameter int FRAC_BITS = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  rtfc_pkg::in_beat_t           in_data_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output rtfc_pkg::out_beat_t                out_data_o,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [rtfc_pkg::ADDR_W-1:0]        paddr,
  input  wire  [rtfc_pkg::DATA_W-1:0]        pwdata,
  output logic [rtfc_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int SB  = rtfc_pkg::SAMPLE_BITS;
  localparam int SUM_W = SB + 2;
  // floor(x/3) = (x*M) >> K, exact for x < 2^SUM_W
  localparam int DIV_K = SUM_W + 2;
  localparam int DIV_P = SUM_W + DIV_K - 1;
  localparam logic [DIV_K-2:0] DIV3_M = (DIV_K-1)'(((1 << DIV_K) + 2) / 3);
  localparam int CW  = rtfc_pkg::DATA_W;
  localparam int PW  = CW + SB + 1;
  localparam int SW  = PW + 2;
  localparam int QW  = rtfc_pkg::SCREEN_BITS;
  localparam logic signed [SW-1:0] RND_BIAS = SW'((1 << FRAC_BITS) - 1);
  localparam logic signed [SW-1:0] SAT_MAX  = SW'((1 << (QW - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_MIN  = SW'(-(1 << (QW - 1)));

  function automatic logic [SB-1:0] div3_rnd(input logic [SUM_W-1:0] s);
    logic [DIV_P-1:0] p;
    p = DIV_P'(SUM_W'(s + SUM_W'(1))) * DIV_P'(DIV3_M);
    return p[DIV_K+SB-1:DIV_K];
  endfunction

  function automatic logic [SB-1:0] absdiff(input logic [SB-1:0] a, input logic [SB-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [SB-1:0] mean2(input logic [SB-1:0] a, input logic [SB-1:0] b);
    logic [SB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SB:1];
  endfunction

  function automatic logic [SB-1:0] pick_pair(
    input logic [SB-1:0] b0, input logic [SB-1:0] b1, input logic [SB-1:0] b2,
    input logic [SB-1:0] d0, input logic [SB-1:0] d1, input logic [SB-1:0] d2);
    logic [SB-1:0] r;
    if (d0 < d1) begin
      r = (d2 < d0) ? mean2(b0, b2) : mean2(b0, b1);
    end else begin
      r = (d2 < d1) ? mean2(b0, b2) : mean2(b1, b2);
    end
    return r;
  endfunction

  function automatic logic signed [QW-1:0] round_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] q;
    logic signed [QW-1:0] r;
    // truncate toward zero: bias negative sums before the arithmetic shift
    t = s + (s[SW-1] ? RND_BIAS : SW'(0));
    q = t >>> FRAC_BITS;
    if (q > SAT_MAX) begin
      r = SAT_MAX[QW-1:0];
    end else if (q < SAT_MIN) begin
      r = SAT_MIN[QW-1:0];
    end else begin
      r = q[QW-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic signed [CW-1:0] coef_xx_q, coef_xy_q, offset_x_q;
  logic signed [CW-1:0] coef_yx_q, coef_yy_q, offset_y_q;
  logic [rtfc_pkg::THRESH_BITS-1:0] move_thr_q;
  rtfc_pkg::reg_idx_e  reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = rtfc_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_xx_q  <= '0;
      coef_xy_q  <= '0;
      offset_x_q <= '0;
      coef_yx_q  <= '0;
      coef_yy_q  <= '0;
      offset_y_q <= '0;
      move_thr_q <= rtfc_pkg::THRESH_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        rtfc_pkg::REG_COEF_XX:  coef_xx_q  <= pwdata;
        rtfc_pkg::REG_COEF_XY:  coef_xy_q  <= pwdata;
        rtfc_pkg::REG_OFFSET_X: offset_x_q <= pwdata;
        rtfc_pkg::REG_COEF_YX:  coef_yx_q  <= pwdata;
        rtfc_pkg::REG_COEF_YY:  coef_yy_q  <= pwdata;
        rtfc_pkg::REG_OFFSET_Y: offset_y_q <= pwdata;
        rtfc_pkg::REG_MOVE_THR: move_thr_q <= pwdata[rtfc_pkg::THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rtfc_pkg::REG_COEF_XX:  prdata = coef_xx_q;
      rtfc_pkg::REG_COEF_XY:  prdata = coef_xy_q;
      rtfc_pkg::REG_OFFSET_X: prdata = offset_x_q;
      rtfc_pkg::REG_COEF_YX:  prdata = coef_yx_q;
      rtfc_pkg::REG_COEF_YY:  prdata = coef_yy_q;
      rtfc_pkg::REG_OFFSET_Y: prdata = offset_y_q;
      rtfc_pkg::REG_MOVE_THR: prdata = CW'(move_thr_q);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- pipeline handshake
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;

  assign rdy_o = !vo_q || !out_stall_i;
  assign rdy5  = !v5_q || rdy_o;
  assign rdy4  = !v4_q || rdy5;
  assign rdy3  = !v3_q || rdy4;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;

  assign in_stall_o = !rdy1;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------- burst accumulation
  logic [1:0]       phase_q, group_q;
  logic [SUM_W-1:0] sum_x_q, sum_y_q;
  logic [SUM_W-1:0] sum_x_d, sum_y_d;
  logic [SUM_W-1:0] hold_x_q [2];
  logic [SUM_W-1:0] hold_y_q [2];
  logic             grp_end, burst_end;

  assign sum_x_d   = sum_x_q + SUM_W'(in_data_i.raw_x);
  assign sum_y_d   = sum_y_q + SUM_W'(in_data_i.raw_y);
  assign grp_end   = (phase_q == 2'd2);
  assign burst_end = grp_end && (group_q == 2'd2) && !in_data_i.pen_up;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      group_q <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else if (in_acc) begin
      if (in_data_i.pen_up) begin
        phase_q <= '0;
        group_q <= '0;
        sum_x_q <= '0;
        sum_y_q <= '0;
      end else if (grp_end) begin
        phase_q <= '0;
        group_q <= (group_q == 2'd2) ? 2'd0 : group_q + 2'd1;
        sum_x_q <= '0;
        sum_y_q <= '0;
      end else begin
        phase_q <= phase_q + 2'd1;
        sum_x_q <= sum_x_d;
        sum_y_q <= sum_y_d;
      end
    end
  end

  // closed sums of the first two groups
  always_ff @(posedge clk_i) begin
    if (in_acc && !in_data_i.pen_up && grp_end && group_q == 2'd0) begin
      hold_x_q[0] <= sum_x_d;
      hold_y_q[0] <= sum_y_d;
    end
    if (in_acc && !in_data_i.pen_up && grp_end && group_q == 2'd1) begin
      hold_x_q[1] <= sum_x_d;
      hold_y_q[1] <= sum_y_d;
    end
  end

  // ---------------------------------------------------------------- stage 1: burst snapshot
  logic [SUM_W-1:0] s1_x_q [3];
  logic [SUM_W-1:0] s1_y_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_x_q[0] <= hold_x_q[0];
      s1_x_q[1] <= hold_x_q[1];
      s1_x_q[2] <= sum_x_d;
      s1_y_q[0] <= hold_y_q[0];
      s1_y_q[1] <= hold_y_q[1];
      s1_y_q[2] <= sum_y_d;
    end
  end

  // ---------------------------------------------------------------- stage 2: group averages
  logic [SB-1:0] avg_x_q [3];
  logic [SB-1:0] avg_y_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      for (int i = 0; i < 3; i++) begin
        avg_x_q[i] <= div3_rnd(s1_x_q[i]);
        avg_y_q[i] <= div3_rnd(s1_y_q[i]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 3: spread, pick
  logic [SB-1:0] dx0, dx1, dx2, dy0, dy1, dy2;
  logic          moving;
  logic [SB-1:0] fx3_q, fy3_q;
  logic          mv3_q;

  assign dx0 = absdiff(avg_x_q[0], avg_x_q[1]);
  assign dx1 = absdiff(avg_x_q[1], avg_x_q[2]);
  assign dx2 = absdiff(avg_x_q[2], avg_x_q[0]);
  assign dy0 = absdiff(avg_y_q[0], avg_y_q[1]);
  assign dy1 = absdiff(avg_y_q[1], avg_y_q[2]);
  assign dy2 = absdiff(avg_y_q[2], avg_y_q[0]);
  assign moving = (dx0 > move_thr_q) || (dx1 > move_thr_q) || (dx2 > move_thr_q) ||
                  (dy0 > move_thr_q) || (dy1 > move_thr_q) || (dy2 > move_thr_q);

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      fx3_q <= pick_pair(avg_x_q[0], avg_x_q[1], avg_x_q[2], dx0, dx1, dx2);
      fy3_q <= pick_pair(avg_y_q[0], avg_y_q[1], avg_y_q[2], dy0, dy1, dy2);
      mv3_q <= moving;
    end
  end

  // ---------------------------------------------------------------- stage 4: products
  logic signed [SB:0]   fx_s, fy_s;
  logic signed [PW-1:0] pxx_q, pxy_q, pyx_q, pyy_q;
  logic [SB-1:0]        fx4_q, fy4_q;
  logic                 mv4_q;

  assign fx_s = {1'b0, fx3_q};
  assign fy_s = {1'b0, fy3_q};

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      pxx_q <= PW'(coef_xx_q) * PW'(fx_s);
      pxy_q <= PW'(coef_xy_q) * PW'(fy_s);
      pyx_q <= PW'(coef_yx_q) * PW'(fx_s);
      pyy_q <= PW'(coef_yy_q) * PW'(fy_s);
      fx4_q <= fx3_q;
      fy4_q <= fy3_q;
      mv4_q <= mv3_q;
    end
  end

  // ---------------------------------------------------------------- stage 5: affine sums
  logic signed [SW-1:0] sx5_q, sy5_q;
  logic [SB-1:0]        fx5_q, fy5_q;
  logic                 mv5_q;

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      sx5_q <= SW'(pxx_q) + SW'(pxy_q) + SW'(offset_x_q);
      sy5_q <= SW'(pyx_q) + SW'(pyy_q) + SW'(offset_y_q);
      fx5_q <= fx4_q;
      fy5_q <= fy4_q;
      mv5_q <= mv4_q;
    end
  end

  // ---------------------------------------------------------------- output register
  rtfc_pkg::out_beat_t out_q;

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      out_q.event_kind <= mv5_q;
      out_q.filtered_x <= fx5_q;
      out_q.filtered_y <= fy5_q;
      out_q.screen_x   <= round_sat(sx5_q);
      out_q.screen_y   <= round_sat(sy5_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1)  v1_q <= in_acc && burst_end;
      if (rdy2)  v2_q <= v1_q;
      if (rdy3)  v3_q <= v2_q;
      if (rdy4)  v4_q <= v3_q;
      if (rdy5)  v5_q <= v4_q;
      if (rdy_o) vo_q <= v5_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------- checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != 2'd3) && (group_q != 2'd3))
    else $error("burst counters out of range");

  a_pen_up_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.pen_up) |=>
      (phase_q == 2'd0) && (group_q == 2'd0) && (sum_x_q == '0) && (sum_y_q == '0))
    else $error("pen-up beat did not drop the partial burst");

  a_burst_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && burst_end) |=> v1_q)
    else $error("ninth sample did not enter the pipeline");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && out_stall_i && v5_q) |=> (v5_q && $stable(sx5_q) && $stable(sy5_q)))
    else $error("stage 5 result lost behind a stalled output");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q && vo_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== tb/resistive_touch_filter_calibrate_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the touch sample burst filter with move detection and affine calibration.
module resistive_touch_filter_calibrate_tb;

  localparam int FRAC_BITS = 16;
  localparam int SB        = rtfc_pkg::SAMPLE_BITS;
  localparam int TB_W      = rtfc_pkg::THRESH_BITS;
  localparam int DW        = rtfc_pkg::DATA_W;
  localparam int AW        = rtfc_pkg::ADDR_W;
  localparam int MAX_RAW   = (1 << SB) - 1;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  rtfc_pkg::in_beat_t  in_data   = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  rtfc_pkg::out_beat_t out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [AW-1:0]       paddr     = '0;
  logic [DW-1:0]       pwdata    = '0;
  logic [DW-1:0]       prdata;
  logic                pready;

  resistive_touch_filter_calibrate #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Mirror of the calibration registers and the burst state.
  logic signed [31:0] cal_xx = '0, cal_xy = '0, cal_ox = '0;
  logic signed [31:0] cal_yx = '0, cal_yy = '0, cal_oy = '0;
  logic [TB_W-1:0]    spread_limit = rtfc_pkg::THRESH_RESET;
  int                 burst_pos = 0;
  int                 acc_x = 0, acc_y = 0;
  int                 grp_x[3], grp_y[3];

  rtfc_pkg::out_beat_t expected_touches[$];
  int        mismatches        = 0;
  int        items_sent        = 0;
  bit        calm              = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // Mostly short pauses, a few long ones.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_pair(int b[3], int d[3]);
    if (d[0] < d[1]) begin
      if (d[2] < d[0]) return (b[0] + b[2]) >> 1;
      return (b[0] + b[1]) >> 1;
    end
    if (d[2] < d[1]) return (b[0] + b[2]) >> 1;
    return (b[1] + b[2]) >> 1;
  endfunction

  function automatic logic signed [rtfc_pkg::SCREEN_BITS-1:0] to_screen(
      logic signed [31:0] cx, logic signed [31:0] cy, logic signed [31:0] off,
      int fx, int fy);
    longint s, q;
    s = longint'(cx) * longint'(fx) + longint'(cy) * longint'(fy) + longint'(off);
    // truncate toward zero, not toward minus infinity
    if (s < 0) q = -((-s) >>> FRAC_BITS);
    else       q = s >>> FRAC_BITS;
    if (q > 32767)  q = 32767;
    if (q < -32768) q = -32768;
    return rtfc_pkg::SCREEN_BITS'(q);
  endfunction

  task automatic track_burst(rtfc_pkg::in_beat_t b);
    int                  dx[3], dy[3];
    int                  j;
    bit                  moving;
    rtfc_pkg::out_beat_t r;
    if (b.pen_up) begin
      burst_pos = 0;
      acc_x     = 0;
      acc_y     = 0;
      return;
    end
    acc_x += int'(b.raw_x);
    acc_y += int'(b.raw_y);
    if (burst_pos % 3 == 2) begin
      grp_x[burst_pos / 3] = (acc_x + 1) / 3;
      grp_y[burst_pos / 3] = (acc_y + 1) / 3;
      acc_x = 0;
      acc_y = 0;
    end
    if (burst_pos < 8) begin
      burst_pos++;
      return;
    end
    burst_pos = 0;
    moving    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      j     = (i + 1) % 3;
      dx[i] = (grp_x[i] > grp_x[j]) ? grp_x[i] - grp_x[j] : grp_x[j] - grp_x[i];
      dy[i] = (grp_y[i] > grp_y[j]) ? grp_y[i] - grp_y[j] : grp_y[j] - grp_y[i];
      if (dx[i] > int'(spread_limit) || dy[i] > int'(spread_limit)) moving = 1'b1;
    end
    r.event_kind = moving;
    r.filtered_x = SB'(pick_pair(grp_x, dx));
    r.filtered_y = SB'(pick_pair(grp_y, dy));
    r.screen_x   = to_screen(cal_xx, cal_xy, cal_ox, int'(r.filtered_x), int'(r.filtered_y));
    r.screen_y   = to_screen(cal_yx, cal_yy, cal_oy, int'(r.filtered_x), int'(r.filtered_y));
    expected_touches.push_back(r);
  endtask

  task automatic check_touch(rtfc_pkg::out_beat_t got);
    rtfc_pkg::out_beat_t want;
    if (expected_touches.size() == 0) begin
      $error("unexpected result beat %p", got);
      mismatches++;
      return;
    end
    want = expected_touches.pop_front();
    if (got.event_kind !== want.event_kind) begin
      $error("event_kind expected %0d got %0d", want.event_kind, got.event_kind);
      mismatches++;
    end
    if (got.filtered_x !== want.filtered_x) begin
      $error("filtered_x expected %0d got %0d", want.filtered_x, got.filtered_x);
      mismatches++;
    end
    if (got.filtered_y !== want.filtered_y) begin
      $error("filtered_y expected %0d got %0d", want.filtered_y, got.filtered_y);
      mismatches++;
    end
    if (got.screen_x !== want.screen_x) begin
      $error("screen_x expected %0d got %0d", want.screen_x, got.screen_x);
      mismatches++;
    end
    if (got.screen_y !== want.screen_y) begin
      $error("screen_y expected %0d got %0d", want.screen_y, got.screen_y);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_touch(out_data);
  end

  // Result side back-pressure.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = calm ? 0 : idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_sample(rtfc_pkg::in_beat_t b);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_burst(b);
    items_sent++;
  endtask

  // Hold the sender until every pending result is out, then let the pipeline empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_touches.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_reg(rtfc_pkg::reg_idx_e idx, logic [DW-1:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= AW'(idx) << 2;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      rtfc_pkg::REG_COEF_XX:  cal_xx = v;
      rtfc_pkg::REG_COEF_XY:  cal_xy = v;
      rtfc_pkg::REG_OFFSET_X: cal_ox = v;
      rtfc_pkg::REG_COEF_YX:  cal_yx = v;
      rtfc_pkg::REG_COEF_YY:  cal_yy = v;
      rtfc_pkg::REG_OFFSET_Y: cal_oy = v;
      rtfc_pkg::REG_MOVE_THR: spread_limit = v[TB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] xx, logic [31:0] xy, logic [31:0] ox,
                           logic [31:0] yx, logic [31:0] yy, logic [31:0] oy,
                           logic [TB_W-1:0] thr);
    drain();
    set_reg(rtfc_pkg::REG_COEF_XX, xx);
    set_reg(rtfc_pkg::REG_COEF_XY, xy);
    set_reg(rtfc_pkg::REG_OFFSET_X, ox);
    set_reg(rtfc_pkg::REG_COEF_YX, yx);
    set_reg(rtfc_pkg::REG_COEF_YY, yy);
    set_reg(rtfc_pkg::REG_OFFSET_Y, oy);
    // junk above the threshold width must be dropped
    set_reg(rtfc_pkg::REG_MOVE_THR, {20'($urandom_range(0, (1 << 20) - 1)), thr});
  endtask

  function automatic logic [31:0] cal_coef();
    return 32'(int'($urandom_range(0, 80000)) - 40000);
  endfunction

  function automatic logic [31:0] cal_offset();
    return 32'(int'($urandom_range(0, 1 << 28)) - (1 << 27));
  endfunction

  function automatic logic [31:0] edge_coef();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [SB-1:0] clamp_raw(int v);
    if (v < 0) return '0;
    if (v > MAX_RAW) return SB'(MAX_RAW);
    return SB'(v);
  endfunction

  function automatic rtfc_pkg::in_beat_t pen_lift();
    rtfc_pkg::in_beat_t b;
    b.pen_up = 1'b1;
    b.raw_x  = SB'($urandom());
    b.raw_y  = SB'($urandom());
    return b;
  endfunction

  // Nine samples around a center with jitter and per-group shifts; sometimes cut short.
  task automatic send_burst();
    int                 cx, cy, spread, cut;
    int                 sx[3], sy[3];
    rtfc_pkg::in_beat_t b;
    cx     = $urandom_range(0, MAX_RAW);
    cy     = $urandom_range(0, MAX_RAW);
    spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 6);
    for (int g = 0; g < 3; g++) begin
      sx[g] = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 600)) - 300 : 0;
      sy[g] = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 600)) - 300 : 0;
    end
    cut = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 8) : 9;
    for (int i = 0; i < 9; i++) begin
      if (i == cut) begin
        send_sample(pen_lift());
        return;
      end
      b.pen_up = 1'b0;
      b.raw_x  = clamp_raw(cx + sx[i / 3] + int'($urandom_range(0, 2 * spread)) - spread);
      b.raw_y  = clamp_raw(cy + sy[i / 3] + int'($urandom_range(0, 2 * spread)) - spread);
      send_sample(b);
    end
  endtask

  task automatic run_phase(int n_items);
    int                 start, r;
    rtfc_pkg::in_beat_t b;
    start = items_sent;
    while (items_sent - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        send_burst();
      end else if (r < 90) begin
        send_sample(pen_lift());
      end else begin
        // stray pen-down samples that throw the burst out of step
        repeat ($urandom_range(1, 4)) begin
          b.pen_up = 1'b0;
          b.raw_x  = SB'($urandom());
          b.raw_y  = SB'($urandom());
          send_sample(b);
        end
        if ($urandom_range(0, 1) == 0) send_sample(pen_lift());
      end
    end
  endtask

  // Reset calibration: all groups equal, full-scale x, zero y, zero screen output.
  task automatic test_still_press();
    rtfc_pkg::in_beat_t b;
    for (int i = 0; i < 9; i++) begin
      b.pen_up = 1'b0;
      b.raw_x  = SB'(MAX_RAW);
      b.raw_y  = '0;
      send_sample(b);
    end
  endtask

  // A partial burst is dropped by pen up; raw fields of the pen-up beat are ignored.
  task automatic test_pen_up_discard();
    rtfc_pkg::in_beat_t b;
    for (int i = 0; i < 4; i++) begin
      b.pen_up = 1'b0;
      b.raw_x  = SB'($urandom());
      b.raw_y  = SB'($urandom());
      send_sample(b);
    end
    b.pen_up = 1'b1;
    b.raw_x  = SB'(MAX_RAW);
    b.raw_y  = SB'(MAX_RAW);
    send_sample(b);
  endtask

  // Extreme coefficients and a zero threshold: widely spread groups, saturated screen.
  task automatic test_moving_extremes();
    rtfc_pkg::in_beat_t b;
    int                 gx[3], gy[3];
    configure(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
    gx = '{0, MAX_RAW, 2048};
    gy = '{MAX_RAW, 0, 1};
    for (int i = 0; i < 9; i++) begin
      b.pen_up = 1'b0;
      b.raw_x  = SB'(gx[i / 3]);
      b.raw_y  = SB'(gy[i / 3]);
      send_sample(b);
    end
  endtask

  task automatic test_random_bursts();
    configure(cal_coef(), cal_coef(), cal_offset(), cal_coef(), cal_coef(), cal_offset(),
              rtfc_pkg::THRESH_RESET);
    run_phase(65);
    configure($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), '0);
    run_phase(65);
    calm = 1'b1;
    configure(cal_coef(), cal_coef(), cal_offset(), cal_coef(), cal_coef(), cal_offset(),
              TB_W'(MAX_RAW));
    run_phase(65);
    calm = 1'b0;
    configure(edge_coef(), edge_coef(), edge_coef(), edge_coef(), edge_coef(), edge_coef(),
              TB_W'($urandom_range(0, 4095)));
    run_phase(65);
    configure(cal_coef(), cal_coef(), cal_offset(), cal_coef(), cal_coef(), cal_offset(),
              TB_W'($urandom_range(0, 40)));
    run_phase(30);
    drain();
    run_phase(30);
    // swapped axes
    configure('0, cal_coef(), cal_offset(), cal_coef(), '0, cal_offset(),
              TB_W'($urandom_range(0, 4095)));
    run_phase(65);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_still_press();
    test_pen_up_discard();
    test_moving_extremes();
    test_random_bursts();
    drain();
    if (mismatches == 0 && expected_touches.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rtfc_pkg.sv
hdl/resistive_touch_filter_calibrate.sv
tb/resistive_touch_filter_calibrate_tb.sv
